>>> hw/rtl/bspm_pkg.sv
// Shared constants and field widths for the bounded servo pulse mapper.
package bspm_pkg;

  localparam int OPCODE_W    = 2;
  localparam int STATUS_W    = 2;
  localparam int POS_FIELD_W = 16;
  localparam int PULSE_W     = 12;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  // Pulse span never exceeds 2400 - 544, so span and quotient fit in 11 bits
  localparam int SPAN_W      = 11;

  localparam logic [OPCODE_W-1:0] OP_INIT     = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_COMMAND  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_SHUTDOWN = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_INIT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_POSITION  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_POSITION  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE_US  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE_US  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SAFE_POSITION = 3'd4;

  localparam logic [PULSE_W-1:0] PULSE_FLOOR_US = 12'd544;
  localparam logic [PULSE_W-1:0] PULSE_CEIL_US  = 12'd2400;

  localparam int unsigned RST_MIN_POSITION  = 0;
  localparam int unsigned RST_MAX_POSITION  = 180;
  localparam int unsigned RST_SAFE_POSITION = 90;

endpackage

>>> hw/rtl/bspm_if.sv
// Valid/ready channel interfaces for command items and result items.
interface bspm_cmd_if import bspm_pkg::*; ;
  logic                   valid;
  logic                   ready;
  logic [OPCODE_W-1:0]    opcode;
  logic [POS_FIELD_W-1:0] target_position;

  modport source (output valid, opcode, target_position, input ready);
  modport sink   (input valid, opcode, target_position, output ready);
endinterface

interface bspm_rsp_if import bspm_pkg::*; ;
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    op_status;
  logic                   intent;
  logic [STATUS_W-1:0]    held_status;
  logic [POS_FIELD_W-1:0] current_position;
  logic [PULSE_W-1:0]     pulse_width_us;

  modport source (output valid, op_status, intent, held_status, current_position,
                  pulse_width_us, input ready);
  modport sink   (input valid, op_status, intent, held_status, current_position,
                  pulse_width_us, output ready);
endinterface

>>> hw/rtl/bounded_servo_pulse_mapper.sv
// Servo position to pulse width mapper with bit-serial multiply and divide.
//
//   channel  dir  handshake          payload
//   cmd      in   valid/ready        opcode, target_position
//   rsp      out  valid/ready        op_status, intent, held_status,
//                                    current_position, pulse_width_us
//   cfg      in   cfg_we, no wait    cfg_index, cfg_data
//
// A mapped item (successful initialize or command) runs 11 shift-add multiply steps
// and 11 restoring divide steps, one bit each; other items go straight to the result.
// One item is in flight at a time.
// The result register lets a new item be accepted while a result waits.
// rst is synchronous and returns configuration, held state and control to reset values.
module bounded_servo_pulse_mapper import bspm_pkg::*; #(
  parameter int POSITION_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  bspm_cmd_if.sink              cmd,
  bspm_rsp_if.source            rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PW     = POSITION_WIDTH;
  localparam int PROD_W = PW + SPAN_W;
  localparam int CNT_W  = $clog2(SPAN_W);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} state_t;
  typedef enum logic [2:0] {
    K_NONE, K_FAIL_INV, K_FAIL_NI, K_SHUT, K_INIT, K_MOVE
  } kind_t;

  // configuration
  logic [PW-1:0]      min_position, max_position, safe_position;
  logic [PULSE_W-1:0] min_pulse_us, max_pulse_us;

  // held state
  logic                is_initialized;
  logic                intent_flag;
  logic [STATUS_W-1:0] stored_status;
  logic [PW-1:0]       held_position;
  logic [PULSE_W-1:0]  held_pulse;

  // item in flight
  state_t              state;
  kind_t               kind;
  logic [STATUS_W-1:0] op_status;
  logic [PW-1:0]       pos;
  logic [PULSE_W-1:0]  pulse_base;
  logic [PW-1:0]       divisor;
  logic [PROD_W-1:0]   mcand;
  logic [SPAN_W-1:0]   mplier;
  logic [PROD_W-1:0]   acc;
  logic [CNT_W-1:0]    cnt;

  // result register
  logic                   out_valid;
  logic [STATUS_W-1:0]    out_status;
  logic                   out_intent;
  logic [STATUS_W-1:0]    out_held_status;
  logic [POS_FIELD_W-1:0] out_position;
  logic [PULSE_W-1:0]     out_pulse;

  // accept-time decision
  logic               accept;
  logic [PW-1:0]      map_pos;
  logic               calib_ok;
  logic               in_range;
  kind_t              kind_next;
  logic [STATUS_W-1:0] op_status_next;

  // divide step
  logic [PW:0]        trial;
  logic [PW-1:0]      rem_next;

  // state update at end of item
  logic                intent_next;
  logic [STATUS_W-1:0] stored_status_next;
  logic [PW-1:0]       held_position_next;
  logic [PULSE_W-1:0]  held_pulse_next;
  logic                is_initialized_next;
  logic                out_free;

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign out_free  = !out_valid || rsp.ready;

  assign rsp.valid            = out_valid;
  assign rsp.op_status        = out_status;
  assign rsp.intent           = out_intent;
  assign rsp.held_status      = out_held_status;
  assign rsp.current_position = out_position;
  assign rsp.pulse_width_us   = out_pulse;

  always_comb begin
    map_pos  = (cmd.opcode == OP_COMMAND) ? cmd.target_position[PW-1:0] : safe_position;
    calib_ok = (min_position < max_position) &&
               (min_pulse_us >= PULSE_FLOOR_US) && (min_pulse_us <= PULSE_CEIL_US) &&
               (max_pulse_us >= PULSE_FLOOR_US) && (max_pulse_us <= PULSE_CEIL_US) &&
               (min_pulse_us < max_pulse_us);
    in_range = (map_pos >= min_position) && (map_pos <= max_position);
    case (cmd.opcode)
      OP_INIT: begin
        if (is_initialized) begin
          kind_next      = K_NONE;
          op_status_next = ST_OK;
        end else if (calib_ok && in_range) begin
          kind_next      = K_INIT;
          op_status_next = ST_OK;
        end else begin
          kind_next      = K_FAIL_INV;
          op_status_next = ST_INVALID;
        end
      end
      OP_COMMAND: begin
        if (!is_initialized) begin
          kind_next      = K_FAIL_NI;
          op_status_next = ST_NOT_INIT;
        end else if (calib_ok && in_range) begin
          kind_next      = K_MOVE;
          op_status_next = ST_OK;
        end else begin
          kind_next      = K_FAIL_INV;
          op_status_next = ST_INVALID;
        end
      end
      OP_SHUTDOWN: begin
        kind_next      = K_SHUT;
        op_status_next = ST_OK;
      end
      default: begin
        kind_next      = K_NONE;
        op_status_next = ST_INVALID;
      end
    endcase
  end

  // restoring divide: upper bits of acc are the remainder, lower bits shift in quotient
  always_comb begin
    trial    = {acc[PROD_W-1:SPAN_W], acc[SPAN_W-1]} - {1'b0, divisor};
    rem_next = trial[PW] ? {acc[PROD_W-2:SPAN_W], acc[SPAN_W-1]} : trial[PW-1:0];
  end

  always_comb begin
    intent_next         = intent_flag;
    stored_status_next  = stored_status;
    held_position_next  = held_position;
    held_pulse_next     = held_pulse;
    is_initialized_next = is_initialized;
    case (kind)
      K_FAIL_INV: stored_status_next = ST_INVALID;
      K_FAIL_NI:  stored_status_next = ST_NOT_INIT;
      K_SHUT: begin
        intent_next         = 1'b0;
        stored_status_next  = ST_NOT_INIT;
        held_position_next  = pos;
        held_pulse_next     = '0;
        is_initialized_next = 1'b0;
      end
      K_INIT, K_MOVE: begin
        intent_next         = (kind == K_MOVE);
        stored_status_next  = ST_OK;
        held_position_next  = pos;
        held_pulse_next     = pulse_base + PULSE_W'(acc[SPAN_W-1:0]);
        is_initialized_next = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_position    <= PW'(RST_MIN_POSITION);
      max_position    <= PW'(RST_MAX_POSITION);
      min_pulse_us    <= PULSE_FLOOR_US;
      max_pulse_us    <= PULSE_CEIL_US;
      safe_position   <= PW'(RST_SAFE_POSITION);
      is_initialized  <= 1'b0;
      intent_flag     <= 1'b0;
      stored_status   <= ST_NOT_INIT;
      held_position   <= PW'(RST_SAFE_POSITION);
      held_pulse      <= '0;
      state           <= S_IDLE;
      kind            <= K_NONE;
      cnt             <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_POSITION:  min_position  <= cfg_data[PW-1:0];
          CFG_MAX_POSITION:  max_position  <= cfg_data[PW-1:0];
          CFG_MIN_PULSE_US:  min_pulse_us  <= cfg_data[PULSE_W-1:0];
          CFG_MAX_PULSE_US:  max_pulse_us  <= cfg_data[PULSE_W-1:0];
          CFG_SAFE_POSITION: safe_position <= cfg_data[PW-1:0];
          default: ;
        endcase
      end

      // drop the result once taken, unless the next one replaces it this cycle
      if (out_valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            kind       <= kind_next;
            op_status  <= op_status_next;
            pos        <= map_pos;
            pulse_base <= min_pulse_us;
            divisor    <= max_position - min_position;
            mcand      <= PROD_W'(map_pos - min_position);
            mplier     <= SPAN_W'(max_pulse_us - min_pulse_us);
            acc        <= '0;
            cnt        <= '0;
            state      <= (kind_next == K_INIT || kind_next == K_MOVE) ? S_MUL : S_DONE;
          end
        end
        S_MUL: begin
          if (mplier[0]) begin
            acc <= acc + mcand;
          end
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          if (cnt == CNT_W'(SPAN_W - 1)) begin
            cnt   <= '0;
            state <= S_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DIV: begin
          acc <= {rem_next, acc[SPAN_W-2:0], ~trial[PW]};
          if (cnt == CNT_W'(SPAN_W - 1)) begin
            cnt   <= '0;
            state <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DONE: begin
          // hold until the result register is free
          if (out_free) begin
            intent_flag     <= intent_next;
            stored_status   <= stored_status_next;
            held_position   <= held_position_next;
            held_pulse      <= held_pulse_next;
            is_initialized  <= is_initialized_next;
            out_valid       <= 1'b1;
            out_status      <= op_status;
            out_intent      <= intent_next;
            out_held_status <= stored_status_next;
            out_position    <= POS_FIELD_W'(held_position_next);
            out_pulse       <= held_pulse_next;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pulse_when_init: assert property (@(posedge clk) disable iff (rst)
    is_initialized |-> (held_pulse >= PULSE_FLOOR_US) && (held_pulse <= PULSE_CEIL_US))
    else $error("held pulse out of range while initialised");

  a_pulse_zero_when_idle: assert property (@(posedge clk) disable iff (rst)
    !is_initialized |-> (held_pulse == '0))
    else $error("pulse driven while uninitialised");

  a_intent_needs_init: assert property (@(posedge clk) disable iff (rst)
    intent_flag |-> is_initialized)
    else $error("intent set without initialisation");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (acc[PROD_W-1:SPAN_W] < divisor))
    else $error("divide remainder not below divisor");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_MUL || state == S_DONE))
    else $error("accepted item did not start");

endmodule

>>> verif/bounded_servo_pulse_mapper_tb.sv
// Self-checking testbench for the bounded servo pulse mapper.
`timescale 1ns / 1ps

module bounded_servo_pulse_mapper_tb;
  import bspm_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned ITEMS_PER_PHASE = 75;
  localparam int unsigned NUM_PHASES = 10;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    op_status;
    logic                   intent;
    logic [STATUS_W-1:0]    held_status;
    logic [POS_FIELD_W-1:0] current_position;
    logic [PULSE_W-1:0]     pulse_width_us;
  } servo_result_t;

  class servo_scoreboard;
    logic [POS_FIELD_W-1:0] min_pos, max_pos, safe_pos;
    logic [PULSE_W-1:0]     min_pulse, max_pulse;
    bit                     armed;
    bit                     holding;
    logic [STATUS_W-1:0]    held_st;
    logic [POS_FIELD_W-1:0] held_pos;
    logic [PULSE_W-1:0]     held_pulse;
    servo_result_t          expected_q[$];
    int unsigned            errors, checked, n_ok, n_invalid, n_not_init, n_mapped;

    function new();
      min_pos    = POS_FIELD_W'(RST_MIN_POSITION);
      max_pos    = POS_FIELD_W'(RST_MAX_POSITION);
      safe_pos   = POS_FIELD_W'(RST_SAFE_POSITION);
      min_pulse  = PULSE_FLOOR_US;
      max_pulse  = PULSE_CEIL_US;
      armed      = 0;
      holding    = 0;
      held_st    = ST_NOT_INIT;
      held_pos   = safe_pos;
      held_pulse = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MIN_POSITION:  min_pos   = data;
        CFG_MAX_POSITION:  max_pos   = data;
        CFG_MIN_PULSE_US:  min_pulse = data[PULSE_W-1:0];
        CFG_MAX_PULSE_US:  max_pulse = data[PULSE_W-1:0];
        CFG_SAFE_POSITION: safe_pos  = data;
        default: ;
      endcase
    endfunction

    function bit calibration_valid();
      return min_pos < max_pos &&
             min_pulse >= PULSE_FLOOR_US && min_pulse <= PULSE_CEIL_US &&
             max_pulse >= PULSE_FLOOR_US && max_pulse <= PULSE_CEIL_US &&
             min_pulse < max_pulse;
    endfunction

    function bit pulse_for(input logic [POS_FIELD_W-1:0] pos, output logic [PULSE_W-1:0] pw);
      int unsigned offset, pos_span, pulse_span;
      pw = '0;
      if (!calibration_valid() || pos < min_pos || pos > max_pos) return 0;
      offset     = int'(pos) - int'(min_pos);
      pos_span   = int'(max_pos) - int'(min_pos);
      pulse_span = int'(max_pulse) - int'(min_pulse);
      pw = PULSE_W'(int'(min_pulse) + (offset * pulse_span) / pos_span);
      return 1;
    endfunction

    function void note_command(logic [OPCODE_W-1:0] op, logic [POS_FIELD_W-1:0] target);
      logic [STATUS_W-1:0] status;
      logic [PULSE_W-1:0]  pw;
      servo_result_t       res;
      status = ST_INVALID;
      case (op)
        OP_INIT: begin
          if (armed) begin
            status = ST_OK;
          end else if (!pulse_for(safe_pos, pw)) begin
            held_st = ST_INVALID;
            status  = ST_INVALID;
          end else begin
            holding    = 0;
            held_st    = ST_OK;
            held_pos   = safe_pos;
            held_pulse = pw;
            armed      = 1;
            status     = ST_OK;
            n_mapped++;
          end
        end
        OP_COMMAND: begin
          if (!armed) begin
            held_st = ST_NOT_INIT;
            status  = ST_NOT_INIT;
          end else if (!pulse_for(target, pw)) begin
            held_st = ST_INVALID;
            status  = ST_INVALID;
          end else begin
            holding    = 1;
            held_st    = ST_OK;
            held_pos   = target;
            held_pulse = pw;
            status     = ST_OK;
            n_mapped++;
          end
        end
        OP_SHUTDOWN: begin
          holding    = 0;
          held_st    = ST_NOT_INIT;
          held_pos   = safe_pos;
          held_pulse = '0;
          armed      = 0;
          status     = ST_OK;
        end
        default: ;  // unused opcode leaves the state alone
      endcase
      case (status)
        ST_OK:       n_ok++;
        ST_INVALID:  n_invalid++;
        ST_NOT_INIT: n_not_init++;
        default: ;
      endcase
      res.op_status        = status;
      res.intent           = holding;
      res.held_status      = held_st;
      res.current_position = held_pos;
      res.pulse_width_us   = held_pulse;
      expected_q.push_back(res);
    endfunction

    function void check_response(servo_result_t got);
      servo_result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("result with no item outstanding: %p", got);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      checked++;
      if (got.op_status !== exp_res.op_status) begin
        $error("op_status: expected %0d, got %0d", exp_res.op_status, got.op_status);
        errors++;
      end
      if (got.intent !== exp_res.intent) begin
        $error("intent: expected %0d, got %0d", exp_res.intent, got.intent);
        errors++;
      end
      if (got.held_status !== exp_res.held_status) begin
        $error("held_status: expected %0d, got %0d", exp_res.held_status, got.held_status);
        errors++;
      end
      if (got.current_position !== exp_res.current_position) begin
        $error("current_position: expected %0d, got %0d",
               exp_res.current_position, got.current_position);
        errors++;
      end
      if (got.pulse_width_us !== exp_res.pulse_width_us) begin
        $error("pulse_width_us: expected %0d, got %0d",
               exp_res.pulse_width_us, got.pulse_width_us);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bspm_cmd_if cmd_ch ();
  bspm_rsp_if rsp_ch ();

  bounded_servo_pulse_mapper dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  servo_scoreboard sb;
  idle_mode_t      idle_mode;
  int unsigned     cycle_count;
  servo_result_t   seen;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b1;
    end else begin
      case (idle_mode)
        IDLE_RECEIVER: rsp_ch.ready <= ($urandom_range(0, 99) >= 67);
        IDLE_BOTH:     rsp_ch.ready <= ($urandom_range(0, 99) >= 35);
        default:       rsp_ch.ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      seen.op_status        = rsp_ch.op_status;
      seen.intent           = rsp_ch.intent;
      seen.held_status      = rsp_ch.held_status;
      seen.current_position = rsp_ch.current_position;
      seen.pulse_width_us   = rsp_ch.pulse_width_us;
      sb.check_response(seen);
    end
  end

  // All driving tasks start and end just after a falling edge.
  task automatic send_item(logic [OPCODE_W-1:0] op, logic [POS_FIELD_W-1:0] target);
    int unsigned gap_pct;
    gap_pct = (idle_mode == IDLE_SENDER) ? 67 : (idle_mode == IDLE_BOTH) ? 35 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid           <= 1'b1;
    cmd_ch.opcode          <= op;
    cmd_ch.target_position <= target;
    do @(posedge clk); while (!cmd_ch.ready);
    sb.note_command(op, target);
    @(negedge clk);
  endtask

  // Hold the sender until every outstanding result has been collected
  task automatic drain_results();
    if (sb.expected_q.size() != 0) begin
      cmd_ch.valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Pulse registers get junk in the unused top bits of the data bus
  task automatic set_calibration(int unsigned mn, int unsigned mx, int unsigned pmin,
                                 int unsigned pmax, int unsigned safe_pt);
    write_reg(CFG_MIN_POSITION, CFG_DATA_W'(mn));
    write_reg(CFG_MAX_POSITION, CFG_DATA_W'(mx));
    write_reg(CFG_MIN_PULSE_US, {4'($urandom), 12'(pmin)});
    write_reg(CFG_MAX_PULSE_US, {4'($urandom), 12'(pmax)});
    write_reg(CFG_SAFE_POSITION, CFG_DATA_W'(safe_pt));
  endtask

  task automatic random_calibration(bit safe_inside);
    int unsigned mn, mx, pmin, pmax;
    mn = $urandom_range(0, 65534);
    if ($urandom_range(0, 1) == 1) begin
      mx = mn + $urandom_range(1, 300);
      if (mx > 65535) mx = 65535;
    end else begin
      mx = $urandom_range(mn + 1, 65535);
    end
    pmin = $urandom_range(544, 2399);
    pmax = $urandom_range(pmin + 1, 2400);
    if (safe_inside) begin
      set_calibration(mn, mx, pmin, pmax, $urandom_range(mn, mx));
    end else begin
      set_calibration(mn, mx, pmin, pmax, (mx + 1 + $urandom_range(0, 1000)) % 65536);
    end
  endtask

  task automatic random_item();
    int unsigned r;
    logic [OPCODE_W-1:0]    op;
    logic [POS_FIELD_W-1:0] target;
    r = $urandom_range(0, 99);
    if (!sb.armed && r < 40) op = OP_INIT;
    else if (r < 8)          op = OP_INIT;
    else if (r < 14)         op = OP_SHUTDOWN;
    else if (r < 17)         op = OP_UNUSED;
    else                     op = OP_COMMAND;
    r = $urandom_range(0, 99);
    if (r < 60 && sb.min_pos <= sb.max_pos) begin
      target = POS_FIELD_W'($urandom_range(sb.min_pos, sb.max_pos));
    end else if (r < 72) begin
      case ($urandom_range(0, 3))
        0:       target = sb.min_pos;
        1:       target = sb.max_pos;
        2:       target = sb.min_pos - 1'b1;
        default: target = sb.max_pos + 1'b1;
      endcase
    end else begin
      target = POS_FIELD_W'($urandom);
    end
    send_item(op, target);
  endtask

  initial begin
    sb           = new();
    idle_mode    = IDLE_NONE;
    cycle_count  = 0;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.opcode          = OP_INIT;
    cmd_ch.target_position = '0;
    rsp_ch.ready = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset calibration 0..180 -> 544..2400 us, safe position 90
    send_item(OP_COMMAND, 16'd0);       // command before initialize
    send_item(OP_INIT, 16'd0);
    send_item(OP_INIT, 16'd7);          // already initialized, no change
    send_item(OP_COMMAND, 16'd0);
    send_item(OP_COMMAND, 16'd180);
    send_item(OP_COMMAND, 16'd181);
    send_item(OP_COMMAND, 16'hFFFF);
    send_item(OP_COMMAND, 16'd1);       // truncating division
    send_item(OP_UNUSED, 16'hA5A5);
    send_item(OP_SHUTDOWN, 16'd0);
    send_item(OP_SHUTDOWN, 16'hFFFF);
    send_item(OP_COMMAND, 16'd45);
    drain_results();
    write_reg(CFG_SAFE_POSITION, 16'd200);
    send_item(OP_INIT, 16'd0);          // safe position cannot be mapped
    send_item(OP_COMMAND, 16'd10);
    drain_results();
    write_reg(CFG_SAFE_POSITION, 16'd90);
    write_reg(CFG_MIN_PULSE_US, 16'd543);
    send_item(OP_INIT, 16'd0);          // pulse floor violated
    drain_results();
    write_reg(CFG_MIN_PULSE_US, 16'd544);
    send_item(OP_INIT, 16'd0);
    drain_results();
    write_reg(CFG_MAX_POSITION, 16'd0); // empty position span, checked live
    send_item(OP_COMMAND, 16'd0);
    drain_results();
    write_reg(CFG_MAX_POSITION, 16'd180);
    send_item(OP_COMMAND, 16'd90);
    send_item(OP_SHUTDOWN, 16'd0);
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      idle_mode = idle_mode_t'(p % 4);
      case (p)
        0: set_calibration(0, 180, 544, 2400, 90);
        1: set_calibration(0, 65535, 544, 2400, 32768);
        2: set_calibration(65534, 65535, 2399, 2400, 65535);
        4: set_calibration(5000, 4000, 600, 2000, 4500);   // positions reversed
        6: set_calibration(0, 65535, 0, 4095, 0);          // pulse limits outside
        7: random_calibration(1'b0);
        8: set_calibration(100, 900, 2000, 1000, 500);     // pulses reversed
        default: random_calibration(1'b1);
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(0, 49) == 0) drain_results();
        random_item();
      end
    end

    drain_results();
    idle_mode = IDLE_NONE;
    repeat (30) @(posedge clk);

    $display("checked %0d results: %0d ok, %0d invalid, %0d not initialized",
             sb.checked, sb.n_ok, sb.n_invalid, sb.n_not_init);
    $display("%0d mapped moves over %0d calibrations and four idling modes",
             sb.n_mapped, NUM_PHASES);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.expected_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
